>>> rtl/spc_pkg.sv
// shared types, constants and helper functions of the planar to chunky converter
`default_nettype none

package spc_pkg;

   localparam int DATA_W          = 8;
   localparam int COL_W           = 10;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 11;
   localparam int RSP_DATA_W      = 24;
   localparam int RSP_USER_W      = 3;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_STORE_DEPTH = 1024;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_COLOR_MODE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERT_MONO = 2'd2;

   typedef enum logic [2:0] {
      MODE_MONO,
      MODE_PLANE2,
      MODE_PLANE4,
      MODE_PLANE8,
      MODE_XRGB1555,
      MODE_RGB565,
      MODE_RGB888,
      MODE_XRGB8888
   } color_mode_type;

   // work items handed from front to back
   typedef enum logic [2:0] {
      OP_MONO,
      OP_STORE,
      OP_PLANAR,
      OP_RGB15,
      OP_RGB16,
      OP_BYTE
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_LAND,
      BK_EMIT
   } back_state_type;

   function automatic int max_xb(input int mw);
      return (mw + 7) / 8;
   endfunction

   // holds the bytes-per-plane count itself
   function automatic int xb_w(input int mw);
      return $clog2(max_xb(mw) + 1);
   endfunction

   function automatic int x_w(input int mw);
      return $clog2(8 * max_xb(mw));
   endfunction

   function automatic int pos_w(input int mw);
      return $clog2(32 * max_xb(mw));
   endfunction

   function automatic int entry_w(input int mw);
      return $bits(op_type) + 16 + pos_w(mw) + x_w(mw) + 2 + 3 + 1;
   endfunction

   // planes kept in the line store: one less than the plane count
   function automatic logic [2:0] lower_planes(input color_mode_type m);
      logic [2:0] r;
      unique case (m)
         MODE_PLANE2: r = 3'd1;
         MODE_PLANE4: r = 3'd3;
         default:     r = 3'd7;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/scanline_planar_to_chunky_top.sv
// top level of the planar/high-color scanline to chunky pixel converter
//
//  port group  dir  transfer carries
//  req_*       in   one bitmap byte per transfer, in file order
//  rsp_*       out  one pixel index, mono bit or color component per transfer
//  csr_*       in   register write, index 0 color mode, 1 line width, 2 mono invert
//
// each input byte is classified in the front as it is accepted; the back takes the work
// item while idle, and for a top-plane byte first reads the lower planes from the line
// store through its single read port (fetch, then land); it then emits the item's results
// (up to 8) into the output register as it frees. a byte kept in the store emits nothing.
// reset is synchronous and clears control state; the line store is not cleared.
// a stalled result is held in the output register while up to two items wait in the
// queue, and the input stalls only when that queue is full.
`default_nettype none

module scanline_planar_to_chunky_top
   import spc_pkg::*;
#(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_W-1:0]     req_tdata,   // [7:0] data_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] pixel_value, [17:8] column
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // [1:0] component, [2] end_of_row
   output logic                       rsp_tlast,   // last_of_run
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int EW  = entry_w(MAX_WIDTH);
   localparam int XBW = xb_w(MAX_WIDTH);

   logic             q_push;
   logic             q_push_ready;
   logic [EW-1:0]    q_push_data;
   logic             q_pop_valid;
   logic             q_pop_ready;
   logic [EW-1:0]    q_pop_data;
   color_mode_type   cfg_mode;
   logic [XBW-1:0]   cfg_xb;

   spc_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_ready    (q_push_ready),
      .q_data     (q_push_data),
      .cfg_mode   (cfg_mode),
      .cfg_xb     (cfg_xb)
   );

   spc_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   spc_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_mode   (cfg_mode),
      .cfg_xb     (cfg_xb),
      .q_valid    (q_pop_valid),
      .q_ready    (q_pop_ready),
      .q_data     (q_pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // work items only enter a queue with room left
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_push_ready)
      else $error("work item pushed into a full queue");

   // the row ends on the last result of its byte
   a_eor_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> rsp_tlast)
      else $error("end of row away from the last result of a byte");

   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1:0] != 2'd3))
      else $error("component code out of range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

>>> rtl/spc_queue.sv
// short work queue between the front and the back
`default_nettype none

module spc_queue
   import spc_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/spc_front.sv
// front end: config registers, scanline position tracking and byte classification
`default_nettype none

module spc_front
   import spc_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [CSR_ADDR_W-1:0]         csr_addr,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [DATA_W-1:0]             req_tdata,
   output logic                               q_push,
   input  wire logic                          q_ready,
   output logic [entry_w(MAX_WIDTH)-1:0]      q_data,
   output color_mode_type                     cfg_mode,
   output logic [xb_w(MAX_WIDTH)-1:0]         cfg_xb
);

   localparam int XBW = xb_w(MAX_WIDTH);
   localparam int XW  = x_w(MAX_WIDTH);
   localparam int PW  = pos_w(MAX_WIDTH);
   localparam int LW  = XW + 1;

   color_mode_type          mode_ff, mode_in;
   logic [CSR_DATA_W-1:0]   width_ff, width_in;
   logic                    invert_ff, invert_in;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [XBW-1:0]          b_ff, b_in;
   logic [2:0]              plane_ff, plane_in;
   logic [1:0]              sub_ff, sub_in;
   logic [XW-1:0]           x_ff, x_in;
   logic [DATA_W-1:0]       held_ff, held_in;

   logic                    accept;
   logic                    csr_hit;
   logic [LW-1:0]           w;
   logic [LW-1:0]           wm1;
   logic [XBW-1:0]          xb;
   logic [PW:0]             len;
   logic                    wrap;
   logic                    b_last;
   logic                    sub_last;
   logic [XW-1:0]           x0;
   logic [LW-1:0]           x_end;
   logic [LW-1:0]           x_left;
   logic                    row_end_pix;
   logic [2:0]              lastk_pix;
   logic                    hc_in_row;
   logic                    hc_row_end;

   op_type                  e_op;
   logic [15:0]             e_word;
   logic [PW-1:0]           e_idx;
   logic [XW-1:0]           e_x;
   logic [1:0]              e_comp;
   logic [2:0]              e_lastk;
   logic                    e_rowend;

   assign req_tready = q_ready;
   assign accept     = req_tvalid && req_tready;
   assign cfg_mode   = mode_ff;
   assign cfg_xb     = xb;
   assign csr_hit    = csr_we && (csr_addr == CSR_COLOR_MODE || csr_addr == CSR_LINE_WIDTH ||
                                  csr_addr == CSR_INVERT_MONO);

   // clamp the programmed width into 1..MAX_WIDTH
   always_comb begin
      if (width_ff == '0) begin
         w = LW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w = LW'(MAX_WIDTH);
      end else begin
         w = LW'(width_ff);
      end
   end

   assign wm1 = w - LW'(1);
   assign xb  = XBW'((w + LW'(7)) >> 3);

   always_comb begin
      unique case (mode_ff)
         MODE_MONO:     len = (PW+1)'(xb);
         MODE_PLANE2:   len = (PW+1)'(xb) << 1;
         MODE_PLANE4:   len = (PW+1)'(xb) << 2;
         MODE_PLANE8:   len = (PW+1)'(xb) << 3;
         MODE_XRGB1555: len = (PW+1)'(xb) << 4;
         MODE_RGB565:   len = (PW+1)'(xb) << 4;
         MODE_RGB888:   len = ((PW+1)'(xb) << 4) + ((PW+1)'(xb) << 3);
         MODE_XRGB8888: len = (PW+1)'(xb) << 5;
      endcase
   end

   always_comb begin
      unique case (mode_ff)
         MODE_XRGB1555, MODE_RGB565: sub_last = (sub_ff == 2'd1);
         MODE_RGB888:                sub_last = (sub_ff == 2'd2);
         MODE_XRGB8888:              sub_last = (sub_ff == 2'd3);
         default:                    sub_last = 1'b1;
      endcase
   end

   assign wrap   = ((PW+1)'(pos_ff) + (PW+1)'(1)) == len;
   assign b_last = (b_ff == xb - XBW'(1));

   // pixel modes: first column of this byte and where the row ends in it
   assign x0          = XW'(b_ff) << 3;
   assign x_end       = LW'(x0) + LW'(7);
   assign x_left      = wm1 - LW'(x0);
   assign row_end_pix = (x_end >= wm1);
   assign lastk_pix   = row_end_pix ? x_left[2:0] : 3'd7;
   assign hc_in_row   = (LW'(x_ff) < w);
   assign hc_row_end  = (LW'(x_ff) == wm1);

   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      invert_in = invert_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_COLOR_MODE:  mode_in   = color_mode_type'(csr_wdata[2:0]);
            CSR_LINE_WIDTH:  width_in  = csr_wdata;
            CSR_INVERT_MONO: invert_in = csr_wdata[0];
            default:         mode_in   = mode_ff;
         endcase
      end
   end

   always_comb begin
      pos_in   = pos_ff;
      b_in     = b_ff;
      plane_in = plane_ff;
      sub_in   = sub_ff;
      x_in     = x_ff;
      held_in  = held_ff;
      if (csr_hit) begin
         pos_in   = '0;
         b_in     = '0;
         plane_in = '0;
         sub_in   = '0;
         x_in     = '0;
      end else if (accept) begin
         if (wrap) begin
            pos_in   = '0;
            b_in     = '0;
            plane_in = '0;
            sub_in   = '0;
            x_in     = '0;
         end else begin
            pos_in = pos_ff + PW'(1);
            if (b_last) begin
               b_in     = '0;
               plane_in = plane_ff + 3'd1;
            end else begin
               b_in = b_ff + XBW'(1);
            end
            if (sub_last) begin
               sub_in = '0;
               x_in   = x_ff + XW'(1);
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         // even byte of a big-endian word
         if ((mode_ff == MODE_XRGB1555 || mode_ff == MODE_RGB565) && !sub_ff[0]) begin
            held_in = req_tdata;
         end
      end
   end

   always_comb begin
      q_push   = 1'b0;
      e_op     = OP_BYTE;
      e_word   = {8'h00, req_tdata};
      e_idx    = '0;
      e_x      = x0;
      e_comp   = 2'd0;
      e_lastk  = 3'd0;
      e_rowend = 1'b0;
      unique case (mode_ff)
         MODE_MONO: begin
            q_push   = accept;
            e_op     = OP_MONO;
            e_word   = {8'h00, req_tdata ^ {DATA_W{invert_ff}}};
            e_lastk  = lastk_pix;
            e_rowend = row_end_pix;
         end
         MODE_PLANE2, MODE_PLANE4, MODE_PLANE8: begin
            q_push = accept;
            if (plane_ff < lower_planes(mode_ff)) begin
               e_op  = OP_STORE;
               e_idx = pos_ff;
            end else begin
               e_op     = OP_PLANAR;
               e_idx    = PW'(b_ff);
               e_lastk  = lastk_pix;
               e_rowend = row_end_pix;
            end
         end
         MODE_XRGB1555, MODE_RGB565: begin
            q_push   = accept && sub_ff[0] && hc_in_row;
            e_op     = (mode_ff == MODE_XRGB1555) ? OP_RGB15 : OP_RGB16;
            e_word   = {held_ff, req_tdata};
            e_x      = x_ff;
            e_lastk  = 3'd2;
            e_rowend = hc_row_end;
         end
         MODE_RGB888: begin
            q_push   = accept && hc_in_row;
            e_x      = x_ff;
            e_comp   = sub_ff;
            e_rowend = hc_row_end && (sub_ff == 2'd2);
         end
         MODE_XRGB8888: begin
            // the pad byte of each group emits nothing
            q_push   = accept && (sub_ff != 2'd0) && hc_in_row;
            e_x      = x_ff;
            e_comp   = sub_ff - 2'd1;
            e_rowend = hc_row_end && (sub_ff == 2'd3);
         end
      endcase
   end

   assign q_data = {e_op, e_word, e_idx, e_x, e_comp, e_lastk, e_rowend};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MONO;
         width_ff  <= CSR_DATA_W'(1);
         invert_ff <= 1'b0;
         pos_ff    <= '0;
         b_ff      <= '0;
         plane_ff  <= '0;
         sub_ff    <= '0;
         x_ff      <= '0;
         held_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         invert_ff <= invert_in;
         pos_ff    <= pos_in;
         b_ff      <= b_in;
         plane_ff  <= plane_in;
         sub_ff    <= sub_in;
         x_ff      <= x_in;
         held_ff   <= held_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/spc_back.sv
// back end: plane line store, plane gather and result output register
`default_nettype none

module spc_back
   import spc_pkg::*;
#(
   parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
   parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire color_mode_type                cfg_mode,
   input  wire logic [xb_w(MAX_WIDTH)-1:0]    cfg_xb,
   input  wire logic                          q_valid,
   output logic                               q_ready,
   input  wire logic [entry_w(MAX_WIDTH)-1:0] q_data,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [RSP_DATA_W-1:0]              rsp_tdata,
   output logic [RSP_USER_W-1:0]              rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int XBW = xb_w(MAX_WIDTH);
   localparam int XW  = x_w(MAX_WIDTH);
   localparam int PW  = pos_w(MAX_WIDTH);
   localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CW  = ((PW > AW) ? PW : AW) + 1;
   localparam int CLW = (XW > COL_W) ? XW : COL_W;

   logic [DATA_W-1:0]   store_mem [STORE_DEPTH];

   logic [2:0]          e_op_raw;
   op_type              e_op;
   logic [15:0]         e_word;
   logic [PW-1:0]       e_idx;
   logic [XW-1:0]       e_x;
   logic [1:0]          e_comp;
   logic [2:0]          e_lastk;
   logic                e_rowend;

   back_state_type      state_ff, state_in;
   op_type              op_ff;
   logic [15:0]         word_ff;
   logic [XW-1:0]       x_ff;
   logic [1:0]          comp_ff;
   logic [2:0]          lastk_ff;
   logic                rowend_ff;
   logic [2:0]          k_ff, k_in;
   logic [2:0]          rd_cnt_ff, rd_cnt_in;
   logic [PW-1:0]       rd_addr_ff, rd_addr_in;
   logic                rd_valid_ff;
   logic [2:0]          rd_sel_ff;
   logic                rd_oob_ff;
   logic [DATA_W-1:0]   mem_q_ff;
   logic [DATA_W-1:0]   planes_ff [7];

   logic                out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]   out_value_ff;
   logic [1:0]          out_comp_ff;
   logic [COL_W-1:0]    out_col_ff;
   logic                out_eor_ff;
   logic                out_last_ff;

   logic                pop;
   logic                out_free;
   logic                emit;
   logic                store_we;
   logic                rd_en;
   logic [CW-1:0]       wr_ext;
   logic [CW-1:0]       rd_ext;
   logic                rd_oob;
   logic [2:0]          np_m1;
   logic [2:0]          bit_sel;
   logic [6:0]          lo_bits;
   logic [DATA_W-1:0]   res_value;
   logic [1:0]          res_comp;
   logic [CLW-1:0]      col_sum;
   logic                res_last;

   assign {e_op_raw, e_word, e_idx, e_x, e_comp, e_lastk, e_rowend} = q_data;
   assign e_op = op_type'(e_op_raw);

   assign np_m1    = lower_planes(cfg_mode);
   assign out_free = !out_valid_ff || rsp_tready;
   assign pop      = q_valid && q_ready;
   assign wr_ext   = CW'(e_idx);
   assign rd_ext   = CW'(rd_addr_ff);
   assign rd_oob   = (rd_ext >= CW'(STORE_DEPTH));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (e_op == OP_PLANAR) begin
                  state_in = BK_FETCH;
               end else if (e_op != OP_STORE) begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_FETCH: begin
            if (rd_cnt_ff == np_m1 - 3'd1) begin
               state_in = BK_LAND;
            end
         end
         BK_LAND: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free && k_ff == lastk_ff) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      q_ready  = (state_ff == BK_IDLE);
      store_we = (state_ff == BK_IDLE) && q_valid && (e_op == OP_STORE) &&
                 (wr_ext < CW'(STORE_DEPTH));
      rd_en    = (state_ff == BK_FETCH);
      emit     = (state_ff == BK_EMIT) && out_free;
   end

   always_comb begin
      k_in       = k_ff;
      rd_cnt_in  = rd_cnt_ff;
      rd_addr_in = rd_addr_ff;
      if (pop) begin
         k_in       = '0;
         rd_cnt_in  = '0;
         rd_addr_in = e_idx;
      end else begin
         if (emit) begin
            k_in = k_ff + 3'd1;
         end
         // lower plane i sits at i * bytes_per_plane + byte
         if (rd_en) begin
            rd_cnt_in  = rd_cnt_ff + 3'd1;
            rd_addr_in = rd_addr_ff + PW'(cfg_xb);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_ext[AW-1:0]] <= e_word[DATA_W-1:0];
      end
      if (rd_en) begin
         mem_q_ff <= store_mem[rd_ext[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      k_ff       <= k_in;
      rd_cnt_ff  <= rd_cnt_in;
      rd_addr_ff <= rd_addr_in;
      rd_sel_ff  <= rd_cnt_ff;
      rd_oob_ff  <= rd_oob;
      if (pop) begin
         op_ff     <= e_op;
         word_ff   <= e_word;
         x_ff      <= e_x;
         comp_ff   <= e_comp;
         lastk_ff  <= e_lastk;
         rowend_ff <= e_rowend;
      end
      // a plane byte is registered in mem_q_ff on its read and then lands in planes_ff
      if (rd_valid_ff) begin
         planes_ff[rd_sel_ff] <= rd_oob_ff ? '0 : mem_q_ff;
      end
   end

   // result k of the current work item, msb first across the byte
   assign bit_sel = 3'd7 - k_ff;

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         lo_bits[i] = (3'(i) < np_m1) ? planes_ff[i][bit_sel] : 1'b0;
      end
   end

   always_comb begin
      res_value = word_ff[DATA_W-1:0];
      res_comp  = 2'd0;
      unique case (op_ff)
         OP_MONO: begin
            res_value = {7'b0, word_ff[bit_sel]};
         end
         OP_PLANAR: begin
            res_value = {1'b0, lo_bits} | (8'(word_ff[bit_sel]) << np_m1);
         end
         OP_RGB15: begin
            res_comp = k_ff[1:0];
            unique case (k_ff[1:0])
               2'd0:    res_value = {word_ff[14:10], 3'b000};
               2'd1:    res_value = {word_ff[9:5], 3'b000};
               default: res_value = {word_ff[4:0], 3'b000};
            endcase
         end
         OP_RGB16: begin
            res_comp = k_ff[1:0];
            unique case (k_ff[1:0])
               2'd0:    res_value = {word_ff[15:11], 3'b000};
               2'd1:    res_value = {word_ff[10:5], 2'b00};
               default: res_value = {word_ff[4:0], 3'b000};
            endcase
         end
         OP_BYTE: begin
            res_comp = comp_ff;
         end
         default: begin
            res_value = word_ff[DATA_W-1:0];
         end
      endcase
   end

   assign col_sum  = (op_ff == OP_MONO || op_ff == OP_PLANAR) ?
                     CLW'(x_ff) + CLW'(k_ff) : CLW'(x_ff);
   assign res_last = (k_ff == lastk_ff);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_value_ff <= res_value;
         out_comp_ff  <= res_comp;
         out_col_ff   <= col_sum[COL_W-1:0];
         out_eor_ff   <= rowend_ff && res_last;
         out_last_ff  <= res_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - DATA_W - COL_W)'(0), out_col_ff, out_value_ff};
   assign rsp_tuser  = {out_eor_ff, out_comp_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire
